### rtl/hbpm_pkg.sv
// Shared types, result codes and character classes for the helix bracket pair matcher.
// No dependencies.
package hbpm_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned IDENT_W = 24;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned PTYPE_W = 4;

  localparam logic [IDENT_W-1:0] IDENT_RESET = 24'h000030;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    KIND_PAIR      = 3'd0,
    KIND_UNMATCHED = 3'd1,
    KIND_MISMATCH  = 3'd2,
    KIND_UNCLOSED  = 3'd3,
    KIND_OVERFLOW  = 3'd4,
    KIND_DONE      = 3'd5
  } kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] helix;
    logic [CHAR_W-1:0] number;
    logic              last;
  } col_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [POS_W-1:0]   open_pos;
    logic [POS_W-1:0]   close_pos;
    logic [PTYPE_W-1:0] ptype;
    logic [IDENT_W-1:0] helix_id;
    logic [CHAR_W-1:0]  bad_char;
    logic               last;
  } res_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_opener(input logic [CHAR_W-1:0] c);
    return (c == 8'h7B) || (c == 8'h5B) || (c == 8'h3C) || (c == 8'h28) ||
           (c == 8'h23) || (c == 8'h2A) || ((c >= 8'h61) && (c <= 8'h6A));
  endfunction

  function automatic logic is_bracket_closer(input logic [CHAR_W-1:0] c);
    return (c == 8'h7D) || (c == 8'h5D) || (c == 8'h3E) || (c == 8'h29);
  endfunction

  function automatic logic is_closer(input logic [CHAR_W-1:0] c);
    return is_bracket_closer(c) || ((c >= 8'h41) && (c <= 8'h4A));
  endfunction

endpackage

### rtl/hbpm_front.sv
// Input side: two-word queue that decouples column intake from the matching engine.
// Depends on hbpm_pkg.
module hbpm_front import hbpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  col_word_t word_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      avail_o,
  output col_word_t word_o
);

  col_word_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign word_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/hbpm_back.sv
// Matching engine: lookahead window, identifier slots, linked stacks, free list, result register.
// Depends on hbpm_pkg.
module hbpm_back import hbpm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = 65536,
  parameter int unsigned STACK_ENTRIES = 4096,
  parameter int unsigned HELIX_IDS     = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  logic      avail_i,
  input  col_word_t word_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_t      res_o
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS);
  localparam int unsigned IW = $clog2(STACK_ENTRIES);
  localparam int unsigned HW = IW + 1;
  localparam int unsigned SW = $clog2(HELIX_IDS);
  localparam logic [HW-1:0] HEAD_EMPTY = {1'b1, {IW{1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_COL, S_SRCH, S_SCMP, S_ALLOC, S_FRD, S_PUSH, S_ERD, S_ECHK,
    S_EMIT, S_SHIFT, S_SCAN, S_SCMP2, S_SERD, S_SREP, S_CLEAR
  } state_e;

  state_e              state_q, ret_q;
  logic                np_q, halted_q, flush_q, use_fl_q, out_valid_q;
  logic [CHAR_W-1:0]   wh_q [3];
  logic [CHAR_W-1:0]   wn_q [3];
  logic [CHAR_W-1:0]   wn_n [3];
  logic [1:0]          fill_q;
  logic [IDENT_W-1:0]  ident_q, ident_n;
  logic [CW-1:0]       col_q;
  logic [CW-1:0]       lastpos_q;
  logic [SW:0]         nused_q, idx_q;
  logic [SW-1:0]       slot_q;
  logic [HW-1:0]       head_q;
  logic [IW:0]         bump_q, fcnt_q;
  logic [IW-1:0]       new_e_q, e_sel;
  res_t                res_q, out_q;

  logic [IDENT_W-1:0]  keys_m  [HELIX_IDS];
  logic [HW-1:0]       heads_m [HELIX_IDS];
  logic [POS_W-1:0]    epos_m  [STACK_ENTRIES];
  logic [CHAR_W-1:0]   echar_m [STACK_ENTRIES];
  logic [HW-1:0]       enext_m [STACK_ENTRIES];
  logic [IW-1:0]       fl_m    [STACK_ENTRIES];

  logic [IDENT_W-1:0]  key_rd_q;
  logic [HW-1:0]       head_rd_q, enext_rd_q;
  logic [POS_W-1:0]    epos_rd_q;
  logic [CHAR_W-1:0]   echar_rd_q;
  logic [IW-1:0]       fl_rd_q;

  logic                key_we, head_we, ent_we, fl_we;
  logic [HW-1:0]       head_wd;
  logic [CHAR_W-1:0]   c;
  logic                c_open, nofree, out_free, letter_ok;
  logic [POS_W-1:0]    pos;
  logic [CW:0]         lp_sum;

  assign c        = wh_q[0];
  assign c_open   = is_opener(c);
  assign nofree   = (fcnt_q == '0) && (bump_q == (IW+1)'(STACK_ENTRIES));
  assign out_free = !out_valid_q || !out_stall_i;
  assign pos      = POS_W'(col_q);
  assign letter_ok = is_bracket_closer(c) || (echar_rd_q == c + 8'd32);
  assign e_sel    = use_fl_q ? fl_rd_q : new_e_q;
  assign lp_sum   = {1'b0, col_q} + (CW+1)'(fill_q);
  assign pop_o    = (state_q == S_IDLE) && avail_i;
  assign out_valid_o = out_valid_q;
  assign res_o    = out_q;

  always_comb begin
    logic stop;
    logic [CHAR_W-1:0] d;
    stop    = 1'b0;
    d       = '0;
    ident_n = ident_q;
    wn_n    = wn_q;
    if (np_q && is_digit(wn_q[0])) begin
      for (int j = 0; j < 3; j++) begin
        if (!stop && (j < int'(fill_q))) begin
          d       = wn_q[j];
          wn_n[j] = CHAR_SPACE;
          if (is_alnum(d)) begin
            if (j == 0)      ident_n = {16'h0, d};
            else if (j == 1) ident_n = {8'h0, d, ident_n[7:0]};
            else             ident_n = {d, ident_n[15:0]};
            if (!is_digit(d)) stop = 1'b1;
          end else begin
            stop = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    key_we  = (state_q == S_SRCH) && (idx_q == nused_q) && c_open &&
              (nused_q != (SW+1)'(HELIX_IDS)) && !nofree;
    ent_we  = (state_q == S_PUSH);
    fl_we   = (state_q == S_ECHK) && letter_ok && (fcnt_q < (IW+1)'(STACK_ENTRIES));
    head_we = ent_we || ((state_q == S_ECHK) && letter_ok);
    head_wd = ent_we ? {1'b0, e_sel} : enext_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (key_we)  keys_m[nused_q[SW-1:0]] <= ident_q;
    if (head_we) heads_m[slot_q] <= head_wd;
    key_rd_q  <= keys_m[idx_q[SW-1:0]];
    head_rd_q <= heads_m[idx_q[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      epos_m[e_sel]  <= pos;
      echar_m[e_sel] <= c;
      enext_m[e_sel] <= head_q;
    end
    epos_rd_q  <= epos_m[head_q[IW-1:0]];
    echar_rd_q <= echar_m[head_q[IW-1:0]];
    enext_rd_q <= enext_m[head_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) fl_m[fcnt_q[IW-1:0]] <= head_q[IW-1:0];
    fl_rd_q <= fl_m[IW'(fcnt_q - 1'b1)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      np_q        <= 1'b1;
      halted_q    <= 1'b0;
      flush_q     <= 1'b0;
      use_fl_q    <= 1'b0;
      out_valid_q <= 1'b0;
      wh_q        <= '{default: '0};
      wn_q        <= '{default: '0};
      fill_q      <= 2'd0;
      ident_q     <= IDENT_RESET;
      col_q       <= '0;
      lastpos_q   <= '0;
      nused_q     <= '0;
      idx_q       <= '0;
      slot_q      <= '0;
      head_q      <= HEAD_EMPTY;
      bump_q      <= '0;
      fcnt_q      <= '0;
      new_e_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) np_q <= cfg_data_i;
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            if (halted_q) begin
              if (word_i.last) state_q <= S_CLEAR;
            end else begin
              wh_q[fill_q] <= word_i.helix;
              wn_q[fill_q] <= word_i.number;
              fill_q       <= fill_q + 2'd1;
              if (word_i.last) begin
                flush_q   <= 1'b1;
                lastpos_q <= (lp_sum >= (CW+1)'(MAX_COLUMNS)) ?
                             CW'(lp_sum - (CW+1)'(MAX_COLUMNS)) : CW'(lp_sum);
                state_q   <= S_COL;
              end else if (fill_q == 2'd2) begin
                state_q <= S_COL;
              end
            end
          end
        end
        S_COL: begin
          ident_q <= ident_n;
          wn_q    <= wn_n;
          idx_q   <= '0;
          state_q <= (c_open || is_closer(c)) ? S_SRCH : S_SHIFT;
        end
        S_SRCH: begin
          if (idx_q == nused_q) begin
            if (c_open) begin
              if ((nused_q == (SW+1)'(HELIX_IDS)) || nofree) begin
                res_q    <= '{KIND_OVERFLOW, '0, pos, '0, ident_q, c, 1'b1};
                halted_q <= 1'b1;
                ret_q    <= S_SHIFT;
                state_q  <= S_EMIT;
              end else begin
                slot_q  <= nused_q[SW-1:0];
                nused_q <= nused_q + 1'b1;
                head_q  <= HEAD_EMPTY;
                state_q <= S_ALLOC;
              end
            end else begin
              res_q    <= '{KIND_UNMATCHED, '0, pos, '0, ident_q, c, 1'b1};
              halted_q <= 1'b1;
              ret_q    <= S_SHIFT;
              state_q  <= S_EMIT;
            end
          end else begin
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (key_rd_q == ident_q) begin
            slot_q <= idx_q[SW-1:0];
            head_q <= head_rd_q;
            if (c_open) begin
              state_q <= S_ALLOC;
            end else if (head_rd_q[IW]) begin
              res_q    <= '{KIND_UNMATCHED, '0, pos, '0, ident_q, c, 1'b1};
              halted_q <= 1'b1;
              ret_q    <= S_SHIFT;
              state_q  <= S_EMIT;
            end else begin
              state_q <= S_ERD;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SRCH;
          end
        end
        S_ALLOC: begin
          if (nofree) begin
            res_q    <= '{KIND_OVERFLOW, '0, pos, '0, ident_q, c, 1'b1};
            halted_q <= 1'b1;
            ret_q    <= S_SHIFT;
            state_q  <= S_EMIT;
          end else if (fcnt_q != '0) begin
            use_fl_q <= 1'b1;
            state_q  <= S_FRD;
          end else begin
            use_fl_q <= 1'b0;
            new_e_q  <= bump_q[IW-1:0];
            bump_q   <= bump_q + 1'b1;
            state_q  <= S_PUSH;
          end
        end
        S_FRD: begin
          fcnt_q  <= fcnt_q - 1'b1;
          state_q <= S_PUSH;
        end
        S_PUSH: state_q <= S_SHIFT;
        S_ERD:  state_q <= S_ECHK;
        S_ECHK: begin
          if (letter_ok) begin
            res_q <= '{KIND_PAIR, epos_rd_q, pos,
                       is_bracket_closer(c) ? 4'd0 : PTYPE_W'(c - 8'h40),
                       ident_q, 8'h00, !flush_q};
            if (fl_we) fcnt_q <= fcnt_q + 1'b1;
          end else begin
            res_q    <= '{KIND_MISMATCH, epos_rd_q, pos, '0, ident_q, c, 1'b1};
            halted_q <= 1'b1;
          end
          ret_q   <= S_SHIFT;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ret_q;
          end
        end
        S_SHIFT: begin
          wh_q   <= '{wh_q[1], wh_q[2], 8'h00};
          wn_q   <= '{wn_q[1], wn_q[2], 8'h00};
          fill_q <= fill_q - 2'd1;
          col_q  <= (col_q == CW'(MAX_COLUMNS - 1)) ? '0 : col_q + 1'b1;
          idx_q  <= '0;
          if (!flush_q)          state_q <= S_IDLE;
          else if (halted_q)     state_q <= S_CLEAR;
          else if (fill_q == 2'd1) state_q <= S_SCAN;
          else                   state_q <= S_COL;
        end
        S_SCAN: begin
          if (idx_q == nused_q) begin
            res_q   <= '{KIND_DONE, '0, POS_W'(lastpos_q), '0, '0, 8'h00, 1'b1};
            ret_q   <= S_CLEAR;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SCMP2;
          end
        end
        S_SCMP2: begin
          if (!head_rd_q[IW]) begin
            head_q  <= head_rd_q;
            ident_q <= key_rd_q;
            state_q <= S_SERD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_SERD: state_q <= S_SREP;
        S_SREP: begin
          res_q   <= '{KIND_UNCLOSED, epos_rd_q, '0, '0, ident_q, echar_rd_q, 1'b1};
          ret_q   <= S_CLEAR;
          state_q <= S_EMIT;
        end
        S_CLEAR: begin
          wh_q     <= '{default: '0};
          wn_q     <= '{default: '0};
          fill_q   <= 2'd0;
          ident_q  <= IDENT_RESET;
          col_q    <= '0;
          nused_q  <= '0;
          bump_q   <= '0;
          fcnt_q   <= '0;
          halted_q <= 1'b0;
          flush_q  <= 1'b0;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/helix_bracket_pair_matcher.sv
// Top level of the helix bracket pair matcher: input queue plus matching engine.
// Depends on hbpm_pkg, hbpm_front, hbpm_back.
//
// Input channel: one alignment column per word (helix_char_i, number_char_i,
// last_column_i), taken when in_valid_i is high and in_stall_o is low. A two-word
// queue sits in front of the engine.
// Output channel: result words (pair records, errors, end report) held in an
// output register until out_stall_i is low; last_result_o marks a column's final word.
// Configuration: cfg_we_i writes cfg_data_i to the numbers-present flag (reset 1).
// Processing: the first two columns of an alignment only fill the window; a later
// column is matched against the identifier slots, one slot key compared at a time;
// a last column adds one such pass per window column, then a scan over the slots
// for the end report. A stalled output holds the engine in place, and the queue
// then fills and raises in_stall_o.
// Reset clears all stream state; stacks and slots need no clearing pass.
module helix_bracket_pair_matcher import hbpm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = 65536,
  parameter int unsigned STACK_ENTRIES = 4096,
  parameter int unsigned HELIX_IDS     = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CHAR_W-1:0]   helix_char_i,
  input  logic [CHAR_W-1:0]   number_char_i,
  input  logic                last_column_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          kind_o,
  output logic [POS_W-1:0]    open_pos_o,
  output logic [POS_W-1:0]    close_pos_o,
  output logic [PTYPE_W-1:0]  pair_type_o,
  output logic [IDENT_W-1:0]  helix_id_o,
  output logic [CHAR_W-1:0]   bad_char_o,
  output logic                last_result_o
);

  col_word_t in_word, q_word;
  logic      q_full, q_avail, q_pop;
  res_t      res;

  assign in_word    = '{helix_char_i, number_char_i, last_column_i};
  assign in_stall_o = q_full;

  hbpm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && !q_full),
    .word_i  (in_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .word_o  (q_word)
  );

  hbpm_back #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .STACK_ENTRIES (STACK_ENTRIES),
    .HELIX_IDS     (HELIX_IDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .avail_i     (q_avail),
    .word_i      (q_word),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o        = res.kind;
  assign open_pos_o    = res.open_pos;
  assign close_pos_o   = res.close_pos;
  assign pair_type_o   = res.ptype;
  assign helix_id_o    = res.helix_id;
  assign bad_char_o    = res.bad_char;
  assign last_result_o = res.last;

endmodule

### tb/tb_top.sv
// Self-checking testbench for helix_bracket_pair_matcher: streams alignment columns,
// predicts pair records and errors in a scoreboard class, checks every result word.
// Depends on hbpm_pkg and the RTL of helix_bracket_pair_matcher.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hbpm_pkg::*;

  localparam int NSLOTS   = 64;
  localparam int NENTRIES = 4096;
  localparam int SETTLE   = 1000;

  class pair_scoreboard;
    bit             numbers_on = 1;
    logic [7:0]     win_h[3];
    logic [7:0]     win_n[3];
    int             fill;
    logic [23:0]    ident;
    int             col;
    logic [23:0]    keys[NSLOTS];
    bit             used[NSLOTS];
    int             stk_pos[NSLOTS][$];
    logic [7:0]     stk_chr[NSLOTS][$];
    int             in_use;
    bit             halted;
    res_t           expq[$];

    function new();
      clear();
    endfunction

    function void clear();
      for (int k = 0; k < 3; k++) begin
        win_h[k] = 0;
        win_n[k] = 0;
      end
      fill = 0;
      ident = IDENT_RESET;
      col = 0;
      for (int k = 0; k < NSLOTS; k++) begin
        used[k] = 0;
        stk_pos[k].delete();
        stk_chr[k].delete();
      end
      in_use = 0;
      halted = 0;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alnum(logic [7:0] c);
      return digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit opens(logic [7:0] c);
      return c == "{" || c == "[" || c == "<" || c == "(" || c == "#" || c == "*" ||
             (c >= "a" && c <= "j");
    endfunction

    function bit bracket_close(logic [7:0] c);
      return c == "}" || c == "]" || c == ">" || c == ")";
    endfunction

    function int find_slot();
      for (int k = 0; k < NSLOTS; k++)
        if (used[k] && keys[k] == ident) return k;
      return -1;
    endfunction

    function void push_result(kind_e k, int op, int cp, int pt, logic [23:0] id,
                              logic [7:0] bad);
      res_t r;
      r.kind = k;
      r.open_pos = op[15:0];
      r.close_pos = cp[15:0];
      r.ptype = pt[3:0];
      r.helix_id = id;
      r.bad_char = bad;
      r.last = 0;
      expq.push_back(r);
    endfunction

    function void match_column();
      int pos;
      logic [7:0] c;
      logic [7:0] d;
      logic [7:0] low;
      int slot;
      pos = col & 16'hFFFF;
      c = win_h[0];
      if (numbers_on && digit(win_n[0])) begin
        for (int j = 0; j < 3 && j < fill; j++) begin
          d = win_n[j];
          win_n[j] = CHAR_SPACE;
          if (!alnum(d)) break;
          case (j)
            0: ident = {16'h0, d};
            1: ident = {8'h0, d, ident[7:0]};
            default: ident = {d, ident[15:0]};
          endcase
          if (!digit(d)) break;
        end
      end
      if (opens(c)) begin
        slot = find_slot();
        if (slot < 0)
          for (int k = NSLOTS - 1; k >= 0; k--)
            if (!used[k]) slot = k;
        if (slot < 0 || in_use == NENTRIES) begin
          push_result(KIND_OVERFLOW, 0, pos, 0, ident, c);
          halted = 1;
        end else begin
          if (!used[slot]) begin
            used[slot] = 1;
            keys[slot] = ident;
            stk_pos[slot].delete();
            stk_chr[slot].delete();
          end
          stk_pos[slot].push_back(pos);
          stk_chr[slot].push_back(c);
          in_use++;
        end
      end else if (bracket_close(c) || (c >= "A" && c <= "J")) begin
        slot = find_slot();
        if (slot < 0 || stk_pos[slot].size() == 0) begin
          push_result(KIND_UNMATCHED, 0, pos, 0, ident, c);
          halted = 1;
        end else if (!bracket_close(c) && stk_chr[slot][$] != c + 8'd32) begin
          push_result(KIND_MISMATCH, stk_pos[slot][$], pos, 0, ident, c);
          halted = 1;
        end else begin
          low = c + 8'd32;
          push_result(KIND_PAIR, stk_pos[slot][$], pos,
                      bracket_close(c) ? 0 : int'(low - "a") + 1, ident, 8'h00);
          void'(stk_pos[slot].pop_back());
          void'(stk_chr[slot].pop_back());
          in_use--;
        end
      end
      win_h[0] = win_h[1];
      win_h[1] = win_h[2];
      win_h[2] = 0;
      win_n[0] = win_n[1];
      win_n[1] = win_n[2];
      win_n[2] = 0;
      fill--;
      col = (col + 1) % 65536;
    endfunction

    function void note_column(logic [7:0] h, logic [7:0] n, logic l);
      int prior;
      int lastpos;
      bit found;
      prior = expq.size();
      if (halted) begin
        if (l) clear();
        return;
      end
      if (fill > 2) fill = 2;
      win_h[fill] = h;
      win_n[fill] = n;
      fill++;
      if (!l) begin
        if (fill == 3) match_column();
      end else begin
        lastpos = (col + fill - 1) % 65536;
        while (fill > 0 && !halted) match_column();
        if (!halted) begin
          found = 0;
          for (int k = 0; k < NSLOTS && !found; k++)
            if (used[k] && stk_pos[k].size() > 0) begin
              push_result(KIND_UNCLOSED, stk_pos[k][$], 0, 0, keys[k], stk_chr[k][$]);
              found = 1;
            end
          if (!found) push_result(KIND_DONE, 0, lastpos, 0, 0, 0);
        end
        clear();
      end
      if (expq.size() > prior) expq[expq.size() - 1].last = 1;
    endfunction

    function bit check_word(res_t got, output string why);
      res_t want;
      why = "";
      if (expq.size() == 0) begin
        why = $sformatf("unexpected word kind=%0d", got.kind);
        return 0;
      end
      want = expq.pop_front();
      if (got.kind != want.kind)
        why = {why, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.open_pos != want.open_pos)
        why = {why, $sformatf(" open_pos %0d/%0d", got.open_pos, want.open_pos)};
      if (got.close_pos != want.close_pos)
        why = {why, $sformatf(" close_pos %0d/%0d", got.close_pos, want.close_pos)};
      if (got.ptype != want.ptype)
        why = {why, $sformatf(" ptype %0d/%0d", got.ptype, want.ptype)};
      if (got.helix_id != want.helix_id)
        why = {why, $sformatf(" helix_id %h/%h", got.helix_id, want.helix_id)};
      if (got.bad_char != want.bad_char)
        why = {why, $sformatf(" bad_char %h/%h", got.bad_char, want.bad_char)};
      if (got.last != want.last)
        why = {why, $sformatf(" last %0d/%0d", got.last, want.last)};
      return why == "";
    endfunction

    function int pending();
      return expq.size();
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we_i = 0;
  logic              cfg_data_i = 0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic [7:0]        helix_char_i = 0;
  logic [7:0]        number_char_i = 0;
  logic              last_column_i = 0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic [2:0]        kind_o;
  logic [15:0]       open_pos_o;
  logic [15:0]       close_pos_o;
  logic [3:0]        pair_type_o;
  logic [23:0]       helix_id_o;
  logic [7:0]        bad_char_o;
  logic              last_result_o;

  pair_scoreboard sb = new();
  int  errors = 0;
  int  sent = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_left = 0;

  helix_bracket_pair_matcher uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .helix_char_i, .number_char_i, .last_column_i,
    .out_valid_o, .out_stall_i, .kind_o, .open_pos_o, .close_pos_o,
    .pair_type_o, .helix_id_o, .bad_char_o, .last_result_o
  );

  always #5 clk_i = ~clk_i;

  task automatic report(string msg);
    if (errors < 50) $display("MISMATCH at %0t:%s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = 3000;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 12);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    string why;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind = kind_e'(kind_o);
      got.open_pos = open_pos_o;
      got.close_pos = close_pos_o;
      got.ptype = pair_type_o;
      got.helix_id = helix_id_o;
      got.bad_char = bad_char_o;
      got.last = last_result_o;
      if (!sb.check_word(got, why)) report(why);
    end
  end

  task automatic send_column(input logic [7:0] h, input logic [7:0] n, input logic l);
    if (!quiet)
      while ($urandom_range(0, 99) < 12) begin
        in_valid_i <= 0;
        @(posedge clk_i);
      end
    in_valid_i <= 1;
    helix_char_i <= h;
    number_char_i <= n;
    last_column_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_column(h, n, l);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_numbers(input bit v);
    drain();
    cfg_data_i <= v;
    cfg_we_i <= 1;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.numbers_on = v;
  endtask

  task automatic send_text(input string h, input string n);
    for (int i = 0; i < h.len(); i++)
      send_column(h[i], (i < n.len()) ? n[i] : ".", i == h.len() - 1);
  endtask

  task automatic send_slot_flood();
    int id;
    for (int k = 0; k < NSLOTS + 1; k++) begin
      id = 100 + k;
      send_column("(", 8'("0" + id / 100), 0);
      send_column(".", 8'("0" + (id / 10) % 10), 0);
      send_column(".", 8'("0" + id % 10), 0);
    end
    send_column(")", ".", 0);
    send_column(".", ".", 1);
  endtask

  task automatic send_random_alignment(input int len);
    string       opens_s;
    string       closes_s;
    logic [7:0]  h[$];
    logic [7:0]  n[$];
    logic [7:0]  stack[$];
    logic [7:0]  c;
    int          id_left;
    int          r;
    opens_s = "{[<(#*abcdefghij";
    closes_s = "}]>)";
    id_left = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        c = 8'($urandom_range(0, 255));
      end else if (r < 45) begin
        c = opens_s[$urandom_range(0, 15)];
        stack.push_back(c);
      end else if (r < 80 && stack.size() > 0) begin
        if (stack[$] >= "a" && stack[$] <= "j") c = stack[$] - 8'd32;
        else c = closes_s[$urandom_range(0, 3)];
        void'(stack.pop_back());
      end else begin
        c = ".";
      end
      h.push_back(c);
      if (id_left > 0) begin
        id_left--;
        n.push_back((id_left == 0 && $urandom_range(0, 1)) ?
                    8'("a" + $urandom_range(0, 25)) : 8'("0" + $urandom_range(0, 9)));
      end else if (stack.size() <= 1 && $urandom_range(0, 99) < 15) begin
        id_left = $urandom_range(0, 2);
        n.push_back(8'("0" + $urandom_range(0, 9)));
      end else if ($urandom_range(0, 99) < 4) begin
        n.push_back(8'($urandom_range(0, 255)));
      end else begin
        n.push_back(".");
      end
    end
    if ($urandom_range(0, 99) < 75)
      while (stack.size() > 0) begin
        c = stack.pop_back();
        h.push_back((c >= "a" && c <= "j") ? c - 8'd32 : closes_s[$urandom_range(0, 3)]);
        n.push_back(".");
      end
    for (int i = 0; i < h.size(); i++) send_column(h[i], n[i], i == h.size() - 1);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_text("{[<(#*ab)]>}", "12a.........");
    send_text("a(B", "9Z.");
    send_text(")((", "0..");
    send_text("jJ(<", "7.3b");
    send_column(8'h00, 8'h00, 1);
    send_column(8'hFF, 8'hFF, 0);
    send_column(8'h00, 8'h00, 1);
    write_numbers(0);
    send_text("(5)", "5x5");
    write_numbers(1);
    send_slot_flood();
    drain();

    for (int a = 0; sent < 470; a++) begin
      quiet = (a >= 20 && a < 30);
      if (a == 5) hold_req = 1;
      if (a % 12 == 11) drain();
      if (a % 17 == 16) write_numbers($urandom_range(0, 1));
      send_random_alignment((a == 5) ? 40 :
                            ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12));
    end
    write_numbers(1);
    drain();

    if (errors == 0 && sb.pending() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
